// File: hdl/rsv_pkg.sv
// shared types and constants for the rsa sign/verify modexp engine
package rsv_pkg;

    localparam int DIGEST_W  = 64;
    localparam int VALUE_W   = 62;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_MODULUS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PUB_EXP  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PRIV_EXP = 2'd2;

    localparam logic [63:0] PUB_EXP_RESET = 64'd65537;

    localparam logic OP_SIGN   = 1'b0;
    localparam logic OP_VERIFY = 1'b1;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;       // capture the input item
        logic div_dig;    // start reducing the digest
        logic div_sig;    // start reducing the signature
        logic div_step;   // one restoring-division step
        logic rep_save;   // keep the reduced digest representative
        logic pow_init;   // set base, exponent and running result
        logic mul_r;      // start result * base
        logic mul_sq;     // start base * base
        logic mul_step;   // one add-and-double step
        logic save_r;     // result <= product
        logic save_b;     // base <= product, shift exponent
        logic out_load;   // write the output register
    } cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic key_err;
        logic op;
        logic e_zero;
        logic e_lsb;
    } sts_t;

endpackage

// File: hdl/rsv_ctrl.sv
// sequencing state machine for the modexp engine
module rsv_ctrl #(
    parameter int KEY_BITS = 62
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    output logic          out_valid,
    input  logic          out_stall,
    output rsv_pkg::cmd_t cmd,
    input  rsv_pkg::sts_t sts
);
    import rsv_pkg::*;

    localparam int CNT_W = $clog2(DIGEST_W);
    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DIGEST_W - 1);
    localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(KEY_BITS - 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_DIV_D,
        S_REP,
        S_DIV_S,
        S_POW_INIT,
        S_POW_CHK,
        S_MUL_R,
        S_SAVE_R,
        S_MUL_B,
        S_SAVE_B,
        S_DONE
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             out_valid_reg, out_valid_next;

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cnt_next   = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (sts.key_err)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.div_dig = 1'b1;
                    state_next  = S_DIV_D;
                end
            end
            S_DIV_D:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == DIV_LAST)
                begin
                    state_next = S_REP;
                end
            end
            S_REP:
            begin
                cmd.rep_save = 1'b1;
                if (sts.op == OP_VERIFY)
                begin
                    cmd.div_sig = 1'b1;
                    state_next  = S_DIV_S;
                end
                else
                begin
                    state_next = S_POW_INIT;
                end
            end
            S_DIV_S:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == DIV_LAST)
                begin
                    state_next = S_POW_INIT;
                end
            end
            S_POW_INIT:
            begin
                cmd.pow_init = 1'b1;
                state_next   = S_POW_CHK;
            end
            S_POW_CHK:
            begin
                if (sts.e_zero)
                begin
                    state_next = S_DONE;
                end
                else if (sts.e_lsb)
                begin
                    cmd.mul_r  = 1'b1;
                    state_next = S_MUL_R;
                end
                else
                begin
                    cmd.mul_sq = 1'b1;
                    state_next = S_MUL_B;
                end
            end
            S_MUL_R:
            begin
                cmd.mul_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == MUL_LAST)
                begin
                    state_next = S_SAVE_R;
                end
            end
            S_SAVE_R:
            begin
                cmd.save_r = 1'b1;
                cmd.mul_sq = 1'b1;
                state_next = S_MUL_B;
            end
            S_MUL_B:
            begin
                cmd.mul_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == MUL_LAST)
                begin
                    state_next = S_SAVE_B;
                end
            end
            S_SAVE_B:
            begin
                cmd.save_b = 1'b1;
                state_next = S_POW_CHK;
            end
            S_DONE:
            begin
                // wait for the output register to free up
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_accept_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("accepted item did not leave idle");

    a_no_result_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || !out_stall))
        else $error("waiting result overwritten");

    a_mul_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MUL_R || state_reg == S_MUL_B) |-> (cnt_reg <= MUL_LAST))
        else $error("multiply step count out of range");

endmodule

// File: hdl/rsv_dpath.sv
// datapath: restoring divider, add-and-double modular multiplier, exponent registers
module rsv_dpath #(
    parameter int KEY_BITS = 62
) (
    input  logic                          clk,
    input  rsv_pkg::cmd_t                 cmd,
    output rsv_pkg::sts_t                 sts,
    input  logic                          op,
    input  logic [rsv_pkg::DIGEST_W-1:0]  digest_prefix,
    input  logic [rsv_pkg::DIGEST_W-1:0]  signature,
    input  logic [KEY_BITS-1:0]           mod_key,
    input  logic [KEY_BITS-1:0]           pub_exp,
    input  logic [KEY_BITS-1:0]           priv_exp,
    output logic [rsv_pkg::VALUE_W-1:0]   value,
    output logic                          match,
    output logic                          status
);
    import rsv_pkg::*;

    logic                op_reg;
    logic [DIGEST_W-1:0] dig_reg;
    logic [DIGEST_W-1:0] sig_reg;
    logic [DIGEST_W-1:0] dvd_reg;
    logic [KEY_BITS-1:0] rem_reg;
    logic [KEY_BITS-1:0] rep_reg;
    logic [KEY_BITS-1:0] r_reg;
    logic [KEY_BITS-1:0] b_reg;
    logic [KEY_BITS-1:0] e_reg;
    logic [KEY_BITS-1:0] x_reg;
    logic [KEY_BITS-1:0] y_reg;
    logic [KEY_BITS-1:0] acc_reg;
    logic [VALUE_W-1:0]  value_reg;
    logic                match_reg;
    logic                status_reg;

    logic                key_err;
    logic                m_one;
    logic [KEY_BITS:0]   mod_ext;
    logic [KEY_BITS:0]   div_t;
    logic [KEY_BITS-1:0] div_rem;
    logic [KEY_BITS-1:0] rep_val;
    logic [KEY_BITS-1:0] rep_adj;
    logic [KEY_BITS:0]   add_sum;
    logic [KEY_BITS-1:0] add_mod;
    logic [KEY_BITS:0]   dbl_sum;
    logic [KEY_BITS-1:0] dbl_mod;

    assign mod_ext = {1'b0, mod_key};
    assign key_err = (mod_key == '0) ||
                     ((op_reg == OP_VERIFY) ? (pub_exp == '0) : (priv_exp == '0));
    assign m_one   = (mod_key == KEY_BITS'(1));

    // restoring division, one dividend bit per step
    assign div_t   = {rem_reg, dvd_reg[DIGEST_W-1]};
    assign div_rem = (div_t >= mod_ext) ? KEY_BITS'(div_t - mod_ext) : div_t[KEY_BITS-1:0];

    // representative is raised to two when below two
    assign rep_val = (rem_reg < KEY_BITS'(2)) ? KEY_BITS'(2) : rem_reg;
    // only a modulus of one leaves it unreduced
    assign rep_adj = (rep_reg >= mod_key) ? (rep_reg - mod_key) : rep_reg;

    // add-and-double step, both operands already below the modulus but for the base under a unit modulus
    assign add_sum = {1'b0, acc_reg} + {1'b0, x_reg};
    assign add_mod = (add_sum >= mod_ext) ? KEY_BITS'(add_sum - mod_ext)
                                          : add_sum[KEY_BITS-1:0];
    assign dbl_sum = {x_reg, 1'b0};
    assign dbl_mod = (dbl_sum >= mod_ext) ? KEY_BITS'(dbl_sum - mod_ext)
                                          : dbl_sum[KEY_BITS-1:0];

    assign sts.key_err = key_err;
    assign sts.op      = op_reg;
    assign sts.e_zero  = (e_reg == '0);
    assign sts.e_lsb   = e_reg[0];

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= op;
            dig_reg <= digest_prefix;
            sig_reg <= signature;
        end

        if (cmd.div_dig)
        begin
            rem_reg <= '0;
            dvd_reg <= dig_reg;
        end
        else if (cmd.div_sig)
        begin
            rem_reg <= '0;
            dvd_reg <= sig_reg;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= div_rem;
            dvd_reg <= {dvd_reg[DIGEST_W-2:0], 1'b0};
        end

        if (cmd.rep_save)
        begin
            rep_reg <= rep_val;
        end

        if (cmd.pow_init)
        begin
            b_reg <= (op_reg == OP_VERIFY) ? rem_reg : rep_adj;
            e_reg <= (op_reg == OP_VERIFY) ? pub_exp : priv_exp;
            r_reg <= m_one ? '0 : KEY_BITS'(1);
        end
        else
        begin
            if (cmd.save_r)
            begin
                r_reg <= acc_reg;
            end
            if (cmd.save_b)
            begin
                b_reg <= acc_reg;
                e_reg <= e_reg >> 1;
            end
        end

        if (cmd.mul_r)
        begin
            x_reg   <= r_reg;
            y_reg   <= b_reg;
            acc_reg <= '0;
        end
        else if (cmd.mul_sq)
        begin
            // on a result save the base is still the old one, as wanted
            x_reg   <= b_reg;
            y_reg   <= b_reg;
            acc_reg <= '0;
        end
        else if (cmd.mul_step)
        begin
            if (y_reg[0])
            begin
                acc_reg <= add_mod;
            end
            x_reg <= dbl_mod;
            y_reg <= y_reg >> 1;
        end

        if (cmd.out_load)
        begin
            value_reg  <= key_err ? '0 : VALUE_W'(r_reg);
            match_reg  <= !key_err && (op_reg == OP_VERIFY) && (r_reg == rep_reg);
            status_reg <= key_err;
        end
    end

    assign value  = value_reg;
    assign match  = match_reg;
    assign status = status_reg;

endmodule

// File: hdl/rsa_sign_verify_modexp_top.sv
// top level of the rsa sign/verify modexp engine: key registers, controller, datapath
// One item is worked at a time; an error item (missing key) returns without any
// arithmetic. Otherwise a sign item first reduces the digest (one 64-step
// restoring division), a verify item also reduces the signature, then for every
// exponent bit up to the highest set one the base is squared, after a multiply
// into the result when the bit is set. Both are done by one shared
// add-and-double modular multiplier doing one step per cycle. The result sits in
// an output register, so the next item may be accepted while it waits to be
// taken. Key registers must be written by the user only while idle; the block
// itself does not enforce it.
module rsa_sign_verify_modexp_top #(
    parameter int KEY_BITS = 62
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [rsv_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [KEY_BITS-1:0]            cfg_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic                           op,
    input  logic [rsv_pkg::DIGEST_W-1:0]   digest_prefix,
    input  logic [rsv_pkg::DIGEST_W-1:0]   signature,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [rsv_pkg::VALUE_W-1:0]    value,
    output logic                           match,
    output logic                           status
);
    import rsv_pkg::*;

    logic [KEY_BITS-1:0] mod_reg;
    logic [KEY_BITS-1:0] pub_reg;
    logic [KEY_BITS-1:0] priv_reg;
    cmd_t                cmd;
    sts_t                sts;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mod_reg  <= '0;
            pub_reg  <= KEY_BITS'(PUB_EXP_RESET);
            priv_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_MODULUS:  mod_reg  <= cfg_data;
                REG_PUB_EXP:  pub_reg  <= cfg_data;
                REG_PRIV_EXP: priv_reg <= cfg_data;
                default:      ;
            endcase
        end
    end

    rsv_ctrl #(
        .KEY_BITS (KEY_BITS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .sts       (sts)
    );

    rsv_dpath #(
        .KEY_BITS (KEY_BITS)
    ) u_dpath (
        .clk           (clk),
        .cmd           (cmd),
        .sts           (sts),
        .op            (op),
        .digest_prefix (digest_prefix),
        .signature     (signature),
        .mod_key       (mod_reg),
        .pub_exp       (pub_reg),
        .priv_exp      (priv_reg),
        .value         (value),
        .match         (match),
        .status        (status)
    );

endmodule

// File: tb/tb_rsa_sign_verify_modexp_top.sv
// self-checking testbench for the rsa sign/verify modexp engine: directed table, then random phases
`timescale 1ns / 1ps

module tb_rsa_sign_verify_modexp_top;
    import rsv_pkg::*;

    localparam int KEY_BITS     = 62;
    localparam int CYCLE_LIMIT  = 4_000_000;
    localparam int DRAIN_CYCLES = 8;
    localparam int TAIL_CYCLES  = 64;
    localparam int RAND_PHASES  = 4;
    localparam int PHASE_ITEMS  = 25;
    localparam int REKEY_EVERY  = 8;
    localparam int PAUSE_AT     = 4;
    localparam int DIR_ROWS     = 19;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    typedef logic [KEY_BITS-1:0] key_t;

    localparam key_t        ONES62 = '1;
    localparam logic [63:0] ONES64 = '1;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               match;
        logic               status;
    } rsa_result_t;

    typedef struct packed {
        logic                rekey;
        key_t                n;
        key_t                e;
        key_t                d;
        logic                op;
        logic [DIGEST_W-1:0] dig;
        logic [DIGEST_W-1:0] sig;
        logic                typed;
        rsa_result_t         want;
    } dir_row_t;

    // key fields are only used on rows with rekey set
    dir_row_t dir_table [DIR_ROWS] = '{
        // after reset: no modulus and no private exponent
        '{1'b0, 62'd0, 62'd0, 62'd0, OP_SIGN, ONES64, 64'd0, 1'b1, '{62'd0, 1'b0, 1'b1}},
        '{1'b0, 62'd0, 62'd0, 62'd0, OP_VERIFY, 64'd0, ONES64, 1'b1, '{62'd0, 1'b0, 1'b1}},
        // textbook key n = 61 * 53, private exponent absent
        '{1'b1, 62'd3233, 62'd17, 62'd0, OP_SIGN, 64'd2790, 64'd0, 1'b1,
          '{62'd0, 1'b0, 1'b1}},
        '{1'b0, 62'd0, 62'd0, 62'd0, OP_VERIFY, 64'd2790, 64'd65, 1'b1,
          '{62'd2790, 1'b1, 1'b0}},
        // public exponent zero
        '{1'b1, 62'd3233, 62'd0, 62'd2753, OP_VERIFY, 64'd2790, 64'd65, 1'b1,
          '{62'd0, 1'b0, 1'b1}},
        '{1'b0, 62'd0, 62'd0, 62'd0, OP_SIGN, 64'd2790, 64'd0, 1'b1, '{62'd65, 1'b0, 1'b0}},
        // full key: digests below two, oversized signature, all-ones fields
        '{1'b1, 62'd3233, 62'd17, 62'd2753, OP_SIGN, 64'd0, 64'd0, 1'b0, '0},
        '{1'b0, 62'd0, 62'd0, 62'd0, OP_SIGN, 64'd1, ONES64, 1'b0, '0},
        '{1'b0, 62'd0, 62'd0, 62'd0, OP_VERIFY, 64'd6023, 64'd3298, 1'b1,
          '{62'd2790, 1'b1, 1'b0}},
        '{1'b0, 62'd0, 62'd0, 62'd0, OP_SIGN, ONES64, 64'd0, 1'b0, '0},
        '{1'b0, 62'd0, 62'd0, 62'd0, OP_VERIFY, ONES64, ONES64, 1'b0, '0},
        // unit modulus
        '{1'b1, 62'd1, 62'd65537, 62'd5, OP_SIGN, 64'd12345, 64'd0, 1'b1,
          '{62'd0, 1'b0, 1'b0}},
        '{1'b0, 62'd0, 62'd0, 62'd0, OP_VERIFY, 64'd0, ONES64, 1'b1, '{62'd0, 1'b0, 1'b0}},
        // modulus two: digest forced to 2, verify never matches
        '{1'b1, 62'd2, 62'd3, 62'd3, OP_SIGN, 64'd5, 64'd0, 1'b1, '{62'd0, 1'b0, 1'b0}},
        '{1'b0, 62'd0, 62'd0, 62'd0, OP_VERIFY, 64'd1, 64'd3, 1'b1, '{62'd1, 1'b0, 1'b0}},
        '{1'b0, 62'd0, 62'd0, 62'd0, OP_VERIFY, 64'd0, 64'd0, 1'b1, '{62'd0, 1'b0, 1'b0}},
        // widest key and exponents
        '{1'b1, ONES62, ONES62, ONES62, OP_SIGN, ONES64, 64'd0, 1'b0, '0},
        '{1'b0, 62'd0, 62'd0, 62'd0, OP_VERIFY, 64'd0, ONES64, 1'b0, '0},
        // modulus cleared again
        '{1'b1, 62'd0, ONES62, ONES62, OP_VERIFY, ONES64, ONES64, 1'b1,
          '{62'd0, 1'b0, 1'b1}}
    };

    logic                 clk;
    logic                 rst_n         = 1'b0;
    logic                 cfg_write     = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index     = '0;
    key_t                 cfg_data      = '0;
    logic                 in_valid      = 1'b0;
    logic                 in_stall;
    logic                 op            = OP_SIGN;
    logic [DIGEST_W-1:0]  digest_prefix = '0;
    logic [DIGEST_W-1:0]  signature     = '0;
    logic                 out_valid;
    logic                 out_stall     = 1'b0;
    logic [VALUE_W-1:0]   value;
    logic                 match;
    logic                 status;

    // shadow of the key registers
    key_t key_n;
    key_t key_e;
    key_t key_d;

    rsa_result_t pending_results [$];
    rsa_result_t want_now;

    int error_count    = 0;
    int cycle_count    = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int sign_count     = 0;
    int verify_count   = 0;
    int match_count    = 0;
    int keyerr_count   = 0;
    int key_sets       = 0;

    rsa_sign_verify_modexp_top #(
        .KEY_BITS(KEY_BITS)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .op           (op),
        .digest_prefix(digest_prefix),
        .signature    (signature),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .value        (value),
        .match        (match),
        .status       (status)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // (x * y) mod m, add-and-double
    function automatic logic [63:0] mod_mul(logic [63:0] x, logic [63:0] y, logic [63:0] m);
        logic [63:0] acc;
        acc = '0;
        x = x % m;
        while (y != 64'd0)
        begin
            if (y[0])
                acc = (acc + x) % m;
            x = (x << 1) % m;
            y = y >> 1;
        end
        return acc;
    endfunction

    // (b ^ k) mod m, right-to-left square-and-multiply
    function automatic logic [63:0] mod_pow(logic [63:0] b, logic [63:0] k, logic [63:0] m);
        logic [63:0] r;
        r = 64'd1;
        if (m == 64'd1)
            return '0;
        b = b % m;
        while (k != 64'd0)
        begin
            if (k[0])
                r = mod_mul(r, b, m);
            b = mod_mul(b, b, m);
            k = k >> 1;
        end
        return r;
    endfunction

    function automatic rsa_result_t rsa_expected(logic o, logic [63:0] dig, logic [63:0] sig);
        rsa_result_t res;
        logic [63:0] m;
        logic [63:0] rep;
        logic [63:0] v;
        res = '0;
        m = {2'b00, key_n};
        if (key_n == '0 || (o == OP_SIGN ? key_d : key_e) == '0)
            res.status = 1'b1;
        else
        begin
            rep = dig % m;
            if (rep < 64'd2)
                rep = 64'd2;
            if (o == OP_SIGN)
                v = mod_pow(rep, {2'b00, key_d}, m);
            else
            begin
                v = mod_pow(sig, {2'b00, key_e}, m);
                res.match = (v == rep);
            end
            res.value = v[VALUE_W-1:0];
        end
        return res;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // random value exactly w bits wide
    function automatic logic [63:0] rand_width(int w);
        return (rand64() & ((64'd1 << w) - 64'd1)) | (64'd1 << (w - 1));
    endfunction

    // mostly short exponents to keep items fast, now and then full width or absent
    function automatic key_t rand_exponent();
        int pick;
        logic [63:0] x;
        pick = $urandom_range(9);
        if (pick == 0)
            x = '0;
        else if (pick == 1)
            x = 64'd65537;
        else if (pick == 2)
            x = rand64();
        else
            x = rand_width($urandom_range(1, 16));
        return x[KEY_BITS-1:0];
    endfunction

    task automatic cfg_wr(logic [CFG_IDX_W-1:0] idx, key_t data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        case (idx)
            REG_MODULUS:  key_n = data;
            REG_PUB_EXP:  key_e = data;
            REG_PRIV_EXP: key_d = data;
            default: ;
        endcase
    endtask

    // hold the sender off until every result is back and the engine has settled
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_key(key_t n, key_t e, key_t d);
        logic [63:0] junk;
        wait_idle();
        junk = rand64();
        cfg_wr(REG_MODULUS, n);
        cfg_wr(REG_PUB_EXP, e);
        cfg_wr(REG_PRIV_EXP, d);
        // unmapped index, must be ignored
        cfg_wr(REG_UNUSED, junk[KEY_BITS-1:0]);
        cfg_write <= 1'b0;
        @(posedge clk);
        key_sets++;
    endtask

    task automatic push_item(logic o, logic [63:0] dig, logic [63:0] sig, logic typed,
                             rsa_result_t want);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid      <= 1'b1;
        op            <= o;
        digest_prefix <= dig;
        signature     <= sig;
        do
            @(posedge clk);
        while (in_stall);
        if (!typed)
            want = rsa_expected(o, dig, sig);
        pending_results.push_back(want);
        if (o == OP_SIGN)
            sign_count++;
        else
            verify_count++;
        if (want.match)
            match_count++;
        if (want.status)
            keyerr_count++;
    endtask

    // result checker and receiver stall
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                error_count++;
                $display("%0t: unexpected result value=%h match=%b status=%b",
                         $time, value, match, status);
            end
            else
            begin
                want_now = pending_results.pop_front();
                if (value !== want_now.value)
                begin
                    error_count++;
                    $display("%0t: value mismatch: expected %h, got %h",
                             $time, want_now.value, value);
                end
                if (match !== want_now.match)
                begin
                    error_count++;
                    $display("%0t: match mismatch: expected %b, got %b",
                             $time, want_now.match, match);
                end
                if (status !== want_now.status)
                begin
                    error_count++;
                    $display("%0t: status mismatch: expected %b, got %b",
                             $time, want_now.status, status);
                end
            end
        end
        out_stall <= rst_n ? ($urandom_range(99) < recv_stall_pct) : 1'b0;
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d results outstanding",
                 cycle_count, pending_results.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        key_t        rn;
        key_t        re;
        key_t        rd;
        logic [63:0] tmp;
        logic [63:0] dig;
        logic [63:0] sig;
        logic [63:0] v;
        logic        o;
        int          pick;

        key_n = '0;
        key_e = PUB_EXP_RESET[KEY_BITS-1:0];
        key_d = '0;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIR_ROWS; i++)
        begin
            if (dir_table[i].rekey)
                set_key(dir_table[i].n, dir_table[i].e, dir_table[i].d);
            push_item(dir_table[i].op, dir_table[i].dig, dir_table[i].sig,
                      dir_table[i].typed, dir_table[i].want);
        end

        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            send_idle_pct  = (ph == 1) ? 52 : (ph == 3) ? 26 : 0;
            recv_stall_pct = (ph == 2) ? 52 : (ph == 3) ? 26 : 0;
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if (i % REKEY_EVERY == 0)
                begin
                    pick = $urandom_range(9);
                    if (pick == 0)
                        tmp = '0;
                    else if (pick == 1)
                        tmp = 64'($urandom_range(1, 3));
                    else
                        tmp = rand_width($urandom_range(8, KEY_BITS)) | 64'd1;
                    rn = tmp[KEY_BITS-1:0];
                    re = rand_exponent();
                    rd = rand_exponent();
                    set_key(rn, re, rd);
                end
                else if (i == PAUSE_AT)
                    wait_idle();

                pick = $urandom_range(99);
                dig = rand64();
                sig = rand64();
                if (pick < 40)
                    o = OP_SIGN;
                else
                begin
                    o = OP_VERIFY;
                    if (pick < 75 && key_n != '0)
                    begin
                        // digest reduces to sig^e mod n: verify matches if that is >= 2 and e != 0
                        if (pick < 57)
                            sig = sig % {2'b00, key_n};
                        v = mod_pow(sig, {2'b00, key_e}, {2'b00, key_n});
                        dig = v + {2'b00, key_n} * 64'($urandom_range(0, 3));
                    end
                end
                push_item(o, dig, sig, 1'b0, '0);
            end
        end

        wait_idle();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (pending_results.size() != 0)
        begin
            error_count++;
            $display("%0t: %0d expected results never arrived", $time, pending_results.size());
        end

        $display("ran %0d sign and %0d verify items over %0d key settings and four idle mixes",
                 sign_count, verify_count, key_sets);
        $display("of these %0d were expected to match and %0d to report a missing key",
                 match_count, keyerr_count);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
